// ===== src/rvx_pkg.sv =====
// ----------------------------------------------------------------------------
// rvx_pkg: shared types and constants of the RV64I execute unit
// Opcodes, the front-to-back request type and default parameter values.
// ----------------------------------------------------------------------------
package rvx_pkg;

  localparam int unsigned XLEN_DEF      = 64;
  localparam int unsigned REG_COUNT_DEF = 32;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPIMMW = 7'h1b;
  localparam logic [6:0] OPC_OPW    = 7'h3b;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [5:0] F6_ZERO = 6'h00;
  localparam logic [5:0] F6_ALT  = 6'h10;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Instruction class assigned by the front end.
  typedef enum logic [3:0] {
    CLS_BAD    = 4'd0,
    CLS_LUI    = 4'd1,
    CLS_AUIPC  = 4'd2,
    CLS_JAL    = 4'd3,
    CLS_JALR   = 4'd4,
    CLS_BRANCH = 4'd5,
    CLS_OPIMM  = 4'd6,
    CLS_OP     = 4'd7,
    CLS_OPIMMW = 4'd8,
    CLS_OPW    = 4'd9
  } cls_e;

  // Classified request passed through the queue.
  typedef struct packed {
    cls_e        cls;
    logic [31:0] word;
  } dec_t;

endpackage

// ===== src/rvx_if.sv =====
// ----------------------------------------------------------------------------
// rvx_in_if / rvx_out_if: request channels of the execute unit
// Valid/ready channels for instruction words and execution results.
// ----------------------------------------------------------------------------
interface rvx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;
  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rvx_out_if #(parameter int unsigned XLEN = 64);
  logic            valid;
  logic            ready;
  logic            write_enable;
  logic [4:0]      dest_index;
  logic [XLEN-1:0] write_value;
  logic [XLEN-1:0] next_pc;
  logic            unsupported;
  modport source (output valid, output write_enable, output dest_index,
                  output write_value, output next_pc, output unsupported,
                  input ready);
  modport sink   (input valid, input write_enable, input dest_index,
                  input write_value, input next_pc, input unsupported,
                  output ready);
endinterface

// ===== src/rvx_front.sv =====
// ----------------------------------------------------------------------------
// rvx_front: instruction classifier
// Accepts instruction words, flags unsupported encodings and queues them.
// ----------------------------------------------------------------------------
module rvx_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  rvx_in_if.sink         in_if,
  output rvx_pkg::dec_t  q_data_o,
  output logic           q_valid_o,
  input  logic           q_pop_i
);

  localparam int unsigned D = rvx_pkg::QUEUE_DEPTH;
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1;

  rvx_pkg::dec_t  mem_q [D];
  logic [AW-1:0]  wr_q, rd_q;
  logic [AW:0]    cnt_q;
  rvx_pkg::cls_e  cls;
  logic [31:0]    w;
  logic [6:0]     f7;
  logic [2:0]     f3;
  logic           push;

  assign w  = in_if.instruction_word;
  assign f7 = w[31:25];
  assign f3 = w[14:12];

  // Classify the opcode and the reserved function fields.
  always_comb begin
    cls = rvx_pkg::CLS_BAD;
    case (w[6:0])
      rvx_pkg::OPC_LUI:   cls = rvx_pkg::CLS_LUI;
      rvx_pkg::OPC_AUIPC: cls = rvx_pkg::CLS_AUIPC;
      rvx_pkg::OPC_JAL:   cls = rvx_pkg::CLS_JAL;
      rvx_pkg::OPC_JALR: begin
        if (f3 == rvx_pkg::F3_ADD) cls = rvx_pkg::CLS_JALR;
      end
      rvx_pkg::OPC_BRANCH: begin
        if (f3 != rvx_pkg::F3_SLT && f3 != rvx_pkg::F3_SLTU) cls = rvx_pkg::CLS_BRANCH;
      end
      rvx_pkg::OPC_OPIMM: begin
        if (f3 == rvx_pkg::F3_SLL) begin
          if (w[31:26] == rvx_pkg::F6_ZERO) cls = rvx_pkg::CLS_OPIMM;
        end else if (f3 == rvx_pkg::F3_SR) begin
          if (w[31:26] == rvx_pkg::F6_ZERO || w[31:26] == rvx_pkg::F6_ALT)
            cls = rvx_pkg::CLS_OPIMM;
        end else begin
          cls = rvx_pkg::CLS_OPIMM;
        end
      end
      rvx_pkg::OPC_OP: begin
        if (f7 == rvx_pkg::F7_ZERO ||
            (f7 == rvx_pkg::F7_ALT && (f3 == rvx_pkg::F3_ADD || f3 == rvx_pkg::F3_SR)))
          cls = rvx_pkg::CLS_OP;
      end
      rvx_pkg::OPC_OPIMMW: begin
        if (f3 == rvx_pkg::F3_ADD ||
            (f3 == rvx_pkg::F3_SLL && f7 == rvx_pkg::F7_ZERO) ||
            (f3 == rvx_pkg::F3_SR && (f7 == rvx_pkg::F7_ZERO || f7 == rvx_pkg::F7_ALT)))
          cls = rvx_pkg::CLS_OPIMMW;
      end
      rvx_pkg::OPC_OPW: begin
        if ((f7 == rvx_pkg::F7_ZERO &&
             (f3 == rvx_pkg::F3_ADD || f3 == rvx_pkg::F3_SLL || f3 == rvx_pkg::F3_SR)) ||
            (f7 == rvx_pkg::F7_ALT && (f3 == rvx_pkg::F3_ADD || f3 == rvx_pkg::F3_SR)))
          cls = rvx_pkg::CLS_OPW;
      end
      default: cls = rvx_pkg::CLS_BAD;
    endcase
  end

  assign in_if.ready = (cnt_q != (AW+1)'(D));
  assign push        = in_if.valid && in_if.ready;
  assign q_valid_o   = (cnt_q != '0);
  assign q_data_o    = mem_q[rd_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= '{cls: cls, word: w};
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(D-1)) ? '0 : wr_q + 1'b1;
      if (q_pop_i) rd_q <= (rd_q == AW'(D-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop_i);
    end
  end

  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(D)) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (AW+1)'(D)) |-> !in_if.ready) else $error("ready while full");

endmodule

// ===== src/rvx_back.sv =====
// ----------------------------------------------------------------------------
// rvx_back: execute stage
// Reads the register file, executes one instruction a cycle unless out_if stalls, updates the PC.
// ----------------------------------------------------------------------------
module rvx_back #(
  parameter int unsigned XLEN      = rvx_pkg::XLEN_DEF,
  parameter int unsigned REG_COUNT = rvx_pkg::REG_COUNT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [XLEN-1:0] cfg_wdata_i,
  input  rvx_pkg::dec_t   q_data_i,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  rvx_out_if.source       out_if
);

  localparam int unsigned RW = $clog2(REG_COUNT);
  localparam int unsigned SW = $clog2(XLEN);

  logic [XLEN-1:0] rf_q [REG_COUNT];
  logic [REG_COUNT-1:0] rv_q;
  logic [XLEN-1:0] pc_q;
  logic            ov_q;
  logic            owe_q, obad_q;
  logic [4:0]      ord_q;
  logic [XLEN-1:0] oval_q, onpc_q;

  logic [31:0]     w;
  logic [2:0]      f3;
  logic [4:0]      rd, rs1, rs2;
  logic [XLEN-1:0] a, b, immi, immu, immb, immj, opb, pc4;
  logic [XLEN-1:0] val, nxt, sum, diff;
  logic [31:0]     a32, s32;
  logic [SW-1:0]   sh;
  logic            writes, bad, take, alt, lts, ltu;
  logic            fire, wr;

  assign w   = q_data_i.word;
  assign f3  = w[14:12];
  assign rd  = w[11:7];
  assign rs1 = w[19:15];
  assign rs2 = w[24:20];
  assign alt = w[30];
  assign a   = (rv_q[RW'(rs1)] && rs1 != '0) ? rf_q[RW'(rs1)] : '0;
  assign b   = (rv_q[RW'(rs2)] && rs2 != '0) ? rf_q[RW'(rs2)] : '0;

  assign immi = {{(XLEN-12){w[31]}}, w[31:20]};
  assign immu = {{(XLEN-32){w[31]}}, w[31:12], 12'h000};
  assign immb = {{(XLEN-12){w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
  assign immj = {{(XLEN-20){w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
  assign pc4  = pc_q + XLEN'(4);

  // Operand selection and shared arithmetic.
  always_comb begin
    case (q_data_i.cls)
      rvx_pkg::CLS_OP, rvx_pkg::CLS_OPW, rvx_pkg::CLS_BRANCH: opb = b;
      default: opb = immi;
    endcase
  end
  assign sum  = a + opb;
  assign diff = a - opb;
  assign ltu  = a < opb;
  assign lts  = (a[XLEN-1] != opb[XLEN-1]) ? a[XLEN-1] : ltu;
  assign a32  = a[31:0];

  // Execute.
  always_comb begin
    val    = '0;
    nxt    = pc4;
    writes = 1'b1;
    bad    = 1'b0;
    take   = 1'b0;
    s32    = '0;
    sh     = opb[SW-1:0];
    case (q_data_i.cls)
      rvx_pkg::CLS_LUI:   val = immu;
      rvx_pkg::CLS_AUIPC: val = pc_q + immu;
      rvx_pkg::CLS_JAL: begin
        val = pc4;
        nxt = pc_q + immj;
      end
      rvx_pkg::CLS_JALR: begin
        val = pc4;
        nxt = {sum[XLEN-1:1], 1'b0};
      end
      rvx_pkg::CLS_BRANCH: begin
        writes = 1'b0;
        case (f3)
          rvx_pkg::F3_BEQ:  take = (a == b);
          rvx_pkg::F3_BNE:  take = (a != b);
          rvx_pkg::F3_BLT:  take = lts;
          rvx_pkg::F3_BGE:  take = !lts;
          rvx_pkg::F3_BLTU: take = ltu;
          rvx_pkg::F3_BGEU: take = !ltu;
          default:          take = 1'b0;
        endcase
        if (take) nxt = pc_q + immb;
      end
      rvx_pkg::CLS_OPIMM, rvx_pkg::CLS_OP: begin
        case (f3)
          rvx_pkg::F3_ADD: begin
            if (q_data_i.cls == rvx_pkg::CLS_OP && alt) val = diff;
            else val = sum;
          end
          rvx_pkg::F3_SLL:  val = a << sh;
          rvx_pkg::F3_SLT:  val = XLEN'(lts);
          rvx_pkg::F3_SLTU: val = XLEN'(ltu);
          rvx_pkg::F3_XOR:  val = a ^ opb;
          rvx_pkg::F3_SR: begin
            if (alt) val = $unsigned($signed(a) >>> sh);
            else     val = a >> sh;
          end
          rvx_pkg::F3_OR:   val = a | opb;
          default:          val = a & opb;
        endcase
      end
      rvx_pkg::CLS_OPIMMW, rvx_pkg::CLS_OPW: begin
        case (f3)
          rvx_pkg::F3_ADD: begin
            if (q_data_i.cls == rvx_pkg::CLS_OPW && alt) s32 = diff[31:0];
            else s32 = sum[31:0];
          end
          rvx_pkg::F3_SLL: s32 = a32 << opb[4:0];
          default: begin
            if (alt) s32 = $unsigned($signed(a32) >>> opb[4:0]);
            else     s32 = a32 >> opb[4:0];
          end
        endcase
        val = {{(XLEN-32){s32[31]}}, s32};
      end
      default: begin
        bad    = 1'b1;
        writes = 1'b0;
      end
    endcase
    if (rd == '0 || !writes) begin
      writes = 1'b0;
      val    = '0;
    end
  end

  // One-entry output register: refilled when empty or being drained.
  assign fire    = q_valid_i && (!ov_q || out_if.ready);
  assign q_pop_o = fire;
  assign wr      = fire && writes;

  always_ff @(posedge clk_i) begin
    if (wr) rf_q[RW'(rd)] <= val;
    if (fire) begin
      owe_q  <= writes;
      ord_q  <= writes ? rd : '0;
      oval_q <= val;
      onpc_q <= nxt;
      obad_q <= bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      rv_q <= '0;
      pc_q <= '0;
    end else begin
      if (fire) ov_q <= 1'b1;
      else if (out_if.ready) ov_q <= 1'b0;
      if (wr) rv_q[RW'(rd)] <= 1'b1;
      if (cfg_we_i) pc_q <= cfg_wdata_i;
      else if (fire) pc_q <= nxt;
    end
  end

  assign out_if.valid        = ov_q;
  assign out_if.write_enable = owe_q;
  assign out_if.dest_index   = ord_q;
  assign out_if.write_value  = oval_q;
  assign out_if.next_pc      = onpc_q;
  assign out_if.unsupported  = obad_q;

  a_bad_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && bad) |=> (!out_if.write_enable && out_if.next_pc == $past(pc4)))
    else $error("unsupported instruction wrote or redirected");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_if.ready) |=> ov_q) else $error("result dropped");
  a_pc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !cfg_we_i) |=> (pc_q == out_if.next_pc)) else $error("pc mismatch");

endmodule

// ===== src/rv64_integer_execute_unit_core.sv =====
// ----------------------------------------------------------------------------
// rv64_integer_execute_unit_core: RV64I integer execute unit
// Classifier front end, two-entry queue and execute back end.
// ----------------------------------------------------------------------------
// One instruction is accepted and executed per cycle while the result side
// keeps taking. The front end classifies each word and places it in a
// two-entry queue; the back end reads the 32 x 64-bit register file,
// executes with shared add, subtract, shift and compare logic, and loads a
// one-entry output register, so an accepted word passes through the queue
// entry and then the output register before its result appears. Register x0
// reads as zero, the register file resets to zero through per-entry valid
// bits, and a configuration write (cfg_we_i) loads the program counter.
module rv64_integer_execute_unit_core #(
  parameter int unsigned XLEN      = rvx_pkg::XLEN_DEF,
  parameter int unsigned REG_COUNT = rvx_pkg::REG_COUNT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [XLEN-1:0] cfg_wdata_i,
  rvx_in_if.sink          in_if,
  rvx_out_if.source       out_if
);

  rvx_pkg::dec_t q_data;
  logic          q_valid, q_pop;

  rvx_front u_front (
    .clk_i, .rst_ni, .in_if,
    .q_data_o(q_data), .q_valid_o(q_valid), .q_pop_i(q_pop)
  );

  rvx_back #(.XLEN(XLEN), .REG_COUNT(REG_COUNT)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .q_data_i(q_data), .q_valid_i(q_valid), .q_pop_o(q_pop), .out_if
  );

endmodule
